// File: sv/b32e_pkg.sv
// Shared types, constants and the symbol-to-character lookup for the base32 encoder.
// Used by b32e_slicer and base32_stream_encoder; depends on nothing else.
`default_nettype none

package b32e_pkg;

    // Bits per base32 symbol and the largest number of characters one byte can cause.
    localparam int K_SYM_W   = 5;
    localparam int K_MAX_SYM = 3;
    localparam int K_CHAR_W  = 7;

    // ASCII bases: 'a' for codes 0..25; for codes 26..31, '2' minus 26.
    localparam logic [K_CHAR_W-1:0] K_ALPHA_BASE = 7'd97;
    localparam logic [K_CHAR_W-1:0] K_DIGIT_BASE = 7'd24;
    localparam logic [K_SYM_W-1:0]  K_NUM_ALPHA  = 5'd26;

    typedef logic [K_SYM_W-1:0] t_sym;

    // One byte's worth of work: its symbols, how many of them are sent, and the flush flag.
    typedef struct packed {
        t_sym [K_MAX_SYM-1:0] syms;
        logic [1:0]           cnt;
        logic                 fin;
    } t_group;

    // Maps a 5-bit code to its lowercase base32 character (a-z, 2-7).
    function automatic logic [K_CHAR_W-1:0] f_b32_char(input t_sym sym);
        logic [K_CHAR_W-1:0] ext;
        ext = {2'b00, sym};
        if (sym < K_NUM_ALPHA) begin
            return K_ALPHA_BASE + ext;
        end else begin
            return K_DIGIT_BASE + ext;
        end
    endfunction

endpackage

`default_nettype wire

// File: sv/b32e_slicer.sv
// Bit accumulator of the base32 encoder: merges leftover bits with a new byte and
// slices the result into up to three 5-bit symbols. Depends on b32e_pkg.
`default_nettype none

module b32e_slicer import b32e_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_load,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_final_byte,
    output t_group          o_group
);

    // Leftover bits (right-aligned, zero above) and how many of them there are (0..4).
    logic [3:0]  r_acc;
    logic [2:0]  r_pend;
    logic [3:0]  n_acc;
    logic [2:0]  n_pend;

    logic [11:0] acc;
    logic [11:0] aligned;
    logic [14:0] window;
    logic [2:0]  shift;
    logic        two_regular;
    logic [2:0]  rem_bits;
    logic [4:0]  rem_mask;
    logic        flush;

    // Left-justify the pending bits plus the new byte, then pad with zeros to three symbols.
    always_comb begin
        acc         = {r_acc, i_data_byte};
        shift       = 3'd4 - r_pend;
        aligned     = acc << shift;
        window      = {aligned, 3'b000};
        two_regular = (r_pend >= 3'd2);
        rem_bits    = two_regular ? (r_pend - 3'd2) : (r_pend + 3'd3);
        rem_mask    = (5'd1 << rem_bits) - 5'd1;
        flush       = i_final_byte && (rem_bits != 3'd0);

        o_group.syms[0] = window[14:10];
        o_group.syms[1] = window[9:5];
        o_group.syms[2] = window[4:0];
        o_group.cnt     = 2'd1 + {1'b0, two_regular} + {1'b0, flush};
        o_group.fin     = i_final_byte;

        // The final byte of a message clears the accumulator.
        if (i_final_byte) begin
            n_acc  = 4'd0;
            n_pend = 3'd0;
        end else begin
            n_acc  = acc[3:0] & rem_mask[3:0];
            n_pend = rem_bits;
        end
    end

    // Accumulator state moves only when a beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= 4'd0;
            r_pend <= 3'd0;
        end else if (i_load) begin
            r_acc  <= n_acc;
            r_pend <= n_pend;
        end
    end

    function automatic logic [3:0] rem_mask_of_pend(input logic [2:0] p);
        logic [4:0] m;
        m = (5'd1 << p) - 5'd1;
        return m[3:0];
    endfunction

    // The pending count never passes four bits.
    a_pend_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= 3'd4)
        else $error("pending bit count out of range");

    // No bits above the pending count are kept.
    a_acc_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_acc & ~rem_mask_of_pend(r_pend)) == 4'd0)
        else $error("accumulator holds stale bits");

    // A final byte leaves nothing pending.
    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load && i_final_byte |=> r_pend == 3'd0)
        else $error("accumulator not cleared after final byte");

endmodule

`default_nettype wire

// File: sv/base32_stream_encoder.sv
// Top level of the unpadded lowercase base32 stream encoder: byte in, characters out.
// Depends on b32e_pkg and b32e_slicer.
//
//   Channel  Direction  Handshake            Beat content
//   input    in         i_valid / o_stall    i_data_byte, i_final_byte
//   output   out        o_valid / i_stall    o_symbol_char, o_last_of_run, o_end_of_message
//
// One character leaves per cycle while the output is not stalled; a byte makes one to three
// characters, 1.6 on average over a long message.
// A byte is taken in the same cycle as the last character of the one before moves to
// the output register; a stalled output holds its character and the waiting byte.
// Reset is synchronous, active low, and empties both stages and the accumulator.
`default_nettype none

module base32_stream_encoder import b32e_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [7:0]          i_data_byte,
    input  wire logic                i_final_byte,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [K_CHAR_W-1:0]      o_symbol_char,
    output logic                     o_last_of_run,
    output logic                     o_end_of_message
);

    t_group      new_group;
    logic        in_take;

    // Work register: the symbols of the byte now being sent.
    t_group      r_group;
    logic        r_item_vld;
    logic [1:0]  r_idx;

    // Result register.
    logic        r_out_vld;
    logic [K_CHAR_W-1:0] r_char;
    logic        r_last;
    logic        r_eom;

    logic        out_free;
    logic        sym_take;
    logic        sym_last;
    logic        item_done;
    t_sym        cur_sym;

    b32e_slicer u_slicer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (in_take),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .o_group      (new_group)
    );

    // Pick the current symbol and decide whether it moves to the result register.
    always_comb begin
        case (r_idx)
            2'd0:    cur_sym = r_group.syms[0];
            2'd1:    cur_sym = r_group.syms[1];
            default: cur_sym = r_group.syms[2];
        endcase
        out_free  = !r_out_vld || !i_stall;
        sym_take  = r_item_vld && out_free;
        sym_last  = (r_idx == (r_group.cnt - 2'd1));
        item_done = sym_take && sym_last;
        o_stall   = r_item_vld && !item_done;
        in_take   = i_valid && !o_stall;
    end

    // Work register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_vld <= 1'b0;
            r_idx      <= 2'd0;
        end else if (in_take) begin
            r_item_vld <= 1'b1;
            r_idx      <= 2'd0;
        end else if (sym_take) begin
            r_idx <= r_idx + 2'd1;
            if (sym_last) begin
                r_item_vld <= 1'b0;
            end
        end
    end

    // Work register payload.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_group <= new_group;
        end
    end

    // Result register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (sym_take) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (sym_take) begin
            r_char <= f_b32_char(cur_sym);
            r_last <= sym_last;
            r_eom  <= sym_last && r_group.fin;
        end
    end

    assign o_valid          = r_out_vld;
    assign o_symbol_char    = r_char;
    assign o_last_of_run    = r_last;
    assign o_end_of_message = r_eom;

    // The symbol index stays inside the byte's character count.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_item_vld |-> (r_idx < r_group.cnt) && (r_group.cnt != 2'd0))
        else $error("symbol index beyond character count");

    // Three characters only come from a flushing final byte.
    a_three_needs_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_item_vld && (r_group.cnt == 2'd3) |-> r_group.fin)
        else $error("three characters without a final byte");

    // End of message is always the last character of its byte.
    a_eom_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_eom |-> r_last)
        else $error("end of message on a non-last character");

endmodule

`default_nettype wire
